@@ rtl/csl_pkg.sv @@
// Package for the C subset lexer: payload types, token kinds, operator codes.
// Used by every module of the lexer; depends on nothing.
package csl_pkg;

   localparam logic [2:0] KIND_CONST = 3'd0;
   localparam logic [2:0] KIND_KEYWORD = 3'd1;
   localparam logic [2:0] KIND_IDENT = 3'd2;
   localparam logic [2:0] KIND_OPER = 3'd3;
   localparam logic [2:0] KIND_DELIM = 3'd4;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_NUM = 2'd1;
   localparam logic [1:0] MODE_ID = 2'd2;
   localparam logic [1:0] MODE_OP = 2'd3;

   localparam logic [3:0] OP_PLUS = 4'd0;
   localparam logic [3:0] OP_MINUS = 4'd1;
   localparam logic [3:0] OP_STAR = 4'd2;
   localparam logic [3:0] OP_SLASH = 4'd3;
   localparam logic [3:0] OP_INC = 4'd7;
   localparam logic [3:0] OP_DEC = 4'd8;
   localparam logic [3:0] OP_EQ = 4'd9;
   localparam logic [3:0] OP_GE = 4'd10;
   localparam logic [3:0] OP_LE = 4'd11;
   localparam logic [3:0] OP_GT = 4'd4;
   localparam logic [3:0] OP_LT = 4'd5;
   localparam logic [3:0] OP_ASSIGN = 4'd6;

   localparam int KW_COUNT = 22;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [63:0] text;
      logic [7:0]  text_length;
      logic [4:0]  keyword_index;
      logic        overflow;
      logic        last;
   } rsp_type;

   // One or two tokens produced by one character.
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } pair_type;

   typedef logic [63:0] kw_text_type [KW_COUNT];

   localparam kw_text_type KW_TEXT = '{
      64'h6669, 64'h65736c65, 64'h656c696877, 64'h6f64, 64'h6b61657262,
      64'h65756e69746e6f63, 64'h746e69, 64'h656c62756f64, 64'h74616f6c66,
      64'h6e7275746572, 64'h72616863, 64'h65736163, 64'h666f657a6973,
      64'h676e6f6c, 64'h74726f6873, 64'h66656465707974, 64'h686374697773,
      64'h64656e6769736e75, 64'h64696f76, 64'h636974617473, 64'h746375727473,
      64'h6f746f67};

   typedef logic [3:0] kw_len_type [KW_COUNT];

   localparam kw_len_type KW_LEN = '{
      4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4,
      4'd4, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4};

endpackage

@@ rtl/c_subset_lexer_unit.sv @@
// Channel  Direction  Payload   Handshake
// req      in         req_type  req_valid / req_ready
// rsp      out        rsp_type  rsp_valid / rsp_ready
//
// One character is accepted per cycle while the token queue has room.
// A character yields zero, one or two tokens; the output sends one token per
// cycle while rsp_ready is high, and the two tokens of one character in turn.
// Reset is synchronous and clears scanner state and the queue.
// A stalled output fills the queue; once three entries wait, req_ready drops.
// Top level of the lexer; depends on csl_pkg, csl_front and csl_back.
module c_subset_lexer_unit #(
   parameter int NUMBER_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  csl_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output csl_pkg::rsp_type  rsp_item
);
   import csl_pkg::*;

   logic     tok_valid;
   pair_type tok_pair;
   logic     can_take;

   assign req_ready = can_take;

   csl_front #(.NUMBER_BITS(NUMBER_BITS)) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid && req_ready),
      .in_item(req_item),
      .tok_valid(tok_valid),
      .tok_pair(tok_pair)
   );

   csl_back u_back (
      .clock(clock),
      .reset(reset),
      .push(tok_valid),
      .push_pair(tok_pair),
      .can_take(can_take),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item)
   );

endmodule

@@ rtl/csl_front.sv @@
// Front end of the lexer: scanner state and token forming, one character a cycle.
// Depends on csl_pkg. Emits a pair of tokens (possibly none) per character.
module csl_front #(
   parameter int NUMBER_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  csl_pkg::req_type   in_item,
   output logic               tok_valid,
   output csl_pkg::pair_type  tok_pair
);
   import csl_pkg::*;

   localparam logic [31:0] MAXV = 32'((64'd1 << NUMBER_BITS) - 64'd1);

   logic [1:0]  mode_ff, mode_in;
   logic [31:0] num_ff, num_in;
   logic [63:0] chars_ff, chars_in;
   logic [7:0]  len_ff, len_in;
   logic [2:0]  op_ff, op_in;
   logic        ovf_ff, ovf_in;
   logic        is_dig, is_alp, is_dlm, is_op;
   logic [2:0]  op_idx;
   logic [3:0]  two_code;
   logic [35:0] num_x10;
   logic [36:0] num_next;
   logic        kw_hit;
   logic [4:0]  kw_idx;
   rsp_type     pend_tok, new_tok, tok_a, tok_b;
   logic        have_a, have_b;
   logic [7:0]  c;

   assign c = in_item.ch;

   always_comb begin
      is_dig = c inside {["0":"9"]};
      is_alp = c inside {["a":"z"], ["A":"Z"]};
      is_dlm = c inside {",", ";", "(", ")", "[", "]", "{", "}", " "};
      is_op = 1'b1;
      case (c)
         "+": op_idx = OP_PLUS[2:0];
         "-": op_idx = OP_MINUS[2:0];
         "*": op_idx = OP_STAR[2:0];
         "/": op_idx = OP_SLASH[2:0];
         ">": op_idx = OP_GT[2:0];
         "<": op_idx = OP_LT[2:0];
         "=": op_idx = OP_ASSIGN[2:0];
         default: begin
            op_idx = OP_PLUS[2:0];
            is_op = 1'b0;
         end
      endcase
   end

   // Keyword compare against all constants in parallel.
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (chars_ff == KW_TEXT[k] && len_ff == {4'd0, KW_LEN[k]}) begin
            kw_hit = 1'b1;
            kw_idx = 5'(k);
         end
      end
      if (ovf_ff || len_ff > 8'd8) kw_hit = 1'b0;
   end

   always_comb begin
      pend_tok = '0;
      case (mode_ff)
         MODE_NUM: begin
            pend_tok.kind = KIND_CONST;
            pend_tok.value = num_ff;
            pend_tok.overflow = ovf_ff;
         end
         MODE_ID: begin
            pend_tok.text = chars_ff;
            pend_tok.text_length = len_ff;
            if (kw_hit) begin
               pend_tok.kind = KIND_KEYWORD;
               pend_tok.keyword_index = kw_idx;
            end else begin
               pend_tok.kind = KIND_IDENT;
               pend_tok.overflow = ovf_ff;
            end
         end
         MODE_OP: begin
            pend_tok.kind = KIND_OPER;
            pend_tok.value = {29'd0, op_ff - 3'd1};
         end
         default: pend_tok = '0;
      endcase
   end

   // The pending operator register holds the operator code plus one.
   always_comb begin
      two_code = '0;
      if (mode_ff == MODE_OP) begin
         if (op_ff == OP_PLUS[2:0] + 3'd1 && c == "+") two_code = OP_INC;
         else if (op_ff == OP_MINUS[2:0] + 3'd1 && c == "-") two_code = OP_DEC;
         else if (op_ff == OP_ASSIGN[2:0] + 3'd1 && c == "=") two_code = OP_EQ;
         else if (op_ff == OP_GT[2:0] + 3'd1 && c == "=") two_code = OP_GE;
         else if (op_ff == OP_LT[2:0] + 3'd1 && c == "=") two_code = OP_LE;
      end
   end

   always_comb begin
      num_x10 = {1'b0, num_ff, 3'd0} + {3'd0, num_ff, 1'b0};
      num_next = {1'b0, num_x10} + {33'd0, c[3:0]};
   end

   always_comb begin
      mode_in = mode_ff;
      num_in = num_ff;
      chars_in = chars_ff;
      len_in = len_ff;
      op_in = op_ff;
      ovf_in = ovf_ff;
      have_a = 1'b0;
      have_b = 1'b0;
      tok_a = pend_tok;
      new_tok = '0;
      if (in_item.end_of_text) begin
         have_a = (mode_ff != MODE_IDLE);
         mode_in = MODE_IDLE;
         num_in = '0;
         chars_in = '0;
         len_in = '0;
         op_in = '0;
         ovf_in = 1'b0;
      end else if (mode_ff == MODE_NUM && is_dig) begin
         if (num_next > {5'd0, MAXV}) begin
            num_in = MAXV;
            ovf_in = 1'b1;
         end else begin
            num_in = num_next[31:0];
         end
      end else if (mode_ff == MODE_ID && (is_dig || is_alp || c == "_")) begin
         if (len_ff < 8'd8) chars_in = chars_ff | ({56'd0, c} << {len_ff[2:0], 3'd0});
         else ovf_in = 1'b1;
         if (len_ff != 8'd255) len_in = len_ff + 8'd1;
      end else if (two_code != '0) begin
         have_a = 1'b1;
         tok_a = '0;
         tok_a.kind = KIND_OPER;
         tok_a.value = {28'd0, two_code};
         mode_in = MODE_IDLE;
         op_in = '0;
      end else begin
         have_a = (mode_ff != MODE_IDLE);
         mode_in = MODE_IDLE;
         num_in = '0;
         chars_in = '0;
         len_in = '0;
         op_in = '0;
         ovf_in = 1'b0;
         if (is_dig) begin
            mode_in = MODE_NUM;
            num_in = {28'd0, c[3:0]};
         end else if (is_alp) begin
            mode_in = MODE_ID;
            chars_in = {56'd0, c};
            len_in = 8'd1;
         end else if (is_op) begin
            mode_in = MODE_OP;
            op_in = op_idx + 3'd1;
         end else if (is_dlm) begin
            have_b = 1'b1;
            new_tok.kind = KIND_DELIM;
            new_tok.value = {24'd0, c};
         end
      end
      tok_b = new_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         num_ff <= '0;
         chars_ff <= '0;
         len_ff <= '0;
         op_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (in_valid) begin
         mode_ff <= mode_in;
         num_ff <= num_in;
         chars_ff <= chars_in;
         len_ff <= len_in;
         op_ff <= op_in;
         ovf_ff <= ovf_in;
      end
   end

   // Pack results so the first slot holds a token when valid; last marks the end.
   always_comb begin
      tok_pair = '0;
      tok_valid = in_valid && (have_a || have_b);
      if (have_a && have_b) begin
         tok_pair.two = 1'b1;
         tok_pair.first = tok_a;
         tok_pair.second = tok_b;
         tok_pair.second.last = 1'b1;
      end else if (have_a) begin
         tok_pair.first = tok_a;
         tok_pair.first.last = 1'b1;
      end else begin
         tok_pair.first = tok_b;
         tok_pair.first.last = 1'b1;
      end
   end

endmodule

@@ rtl/csl_back.sv @@
// Back end of the lexer: token pair queue and output serializer.
// Depends on csl_pkg. Emits up to two tokens per entry, one per ready cycle.
module csl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csl_pkg::pair_type  push_pair,
   output logic               can_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output csl_pkg::rsp_type   rsp_item
);
   import csl_pkg::*;

   localparam int DEPTH = 4;

   pair_type   mem_ff [DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       half_ff, half_in;
   logic       pop;
   pair_type   head;

   assign head = mem_ff[rd_ff];
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_item = half_ff ? head.second : head.first;
   // Keeps one slot spare so the front never has to look at the pop.
   assign can_take = (cnt_ff < 3'(DEPTH - 1));

   always_comb begin
      pop = 1'b0;
      half_in = half_ff;
      if (rsp_valid && rsp_ready) begin
         if (head.two && !half_ff) half_in = 1'b1;
         else begin
            half_in = 1'b0;
            pop = 1'b1;
         end
      end
      wr_in = push ? wr_ff + 2'd1 : wr_ff;
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
         half_ff <= half_in;
      end
   end

endmodule
